>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the files that check their own logic.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define STHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define STHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sthc_pkg.sv
`timescale 1ns / 1ps

package sthc_pkg;

    // Input word kinds.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Bytes the parser reacts to.
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_LOWER_S  = 8'h73;
    localparam logic [7:0] BYTE_UPPER_S  = 8'h53;
    localparam logic [7:0] BYTE_KEY_A    = 8'h41;
    localparam logic [7:0] BYTE_KEY_B    = 8'h42;
    localparam logic [7:0] BYTE_KEY_C    = 8'h43;
    localparam logic [7:0] BYTE_KEY_D    = 8'h44;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_DRIVE_DUTY    = 2'd0;
    localparam logic [1:0] CFG_PWM_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [6:0]  DUTY_RESET    = 7'd22;
    localparam logic [15:0] PERIOD_RESET  = 16'd3199;
    localparam logic [15:0] TIMEOUT_RESET = 16'd400;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // Motion and event codes as they appear on the output.
    typedef enum logic [2:0] {
        MOT_STOP  = 3'd0,
        MOT_FWD   = 3'd1,
        MOT_REV   = 3'd2,
        MOT_LEFT  = 3'd3,
        MOT_RIGHT = 3'd4
    } motion_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_COMMAND = 2'd1,
        EVT_TIMEOUT = 2'd2
    } event_t;

    // One classified word handed from the parser to the drive stage.
    typedef struct packed {
        motion_t motion;
        event_t  evt;
    } motion_item_t;

    // Division by 100 is done as a multiply by ceil(2^30 / 100) and a shift.
    // The product duty * (period + 1) stays below 2^23, which keeps the
    // truncated quotient exact. The duty clamp to 100 is folded into the table.
    localparam int          RECIP_SHIFT = 30;
    localparam longint      RECIP_100   = 64'd10737419;
    localparam int          DUTY_MAX    = 100;

    typedef logic [30:0] duty_factor_t;
    typedef duty_factor_t duty_table_t [128];

    function automatic duty_table_t build_duty_table();
        duty_table_t t;
        longint      d_eff;
        for (int d = 0; d < 128; d++)
        begin
            d_eff = (d > DUTY_MAX) ? longint'(DUTY_MAX) : longint'(d);
            t[d]  = 31'(d_eff * RECIP_100);
        end
        return t;
    endfunction

    localparam duty_table_t DUTY_FACTOR = build_duty_table();

endpackage

>>> rtl/core/sthc_if.sv
`timescale 1ns / 1ps

// Input channel: one received byte or one millisecond tick per word.
interface sthc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// Output channel: compare values for all four motors plus status.
interface sthc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] m0_fwd_compare;
    logic [15:0] m0_rev_compare;
    logic [15:0] m1_fwd_compare;
    logic [15:0] m1_rev_compare;
    logic [15:0] m2_fwd_compare;
    logic [15:0] m2_rev_compare;
    logic [15:0] m3_fwd_compare;
    logic [15:0] m3_rev_compare;
    logic [2:0]  active_motion;
    logic [1:0]  event_code;

    modport source (
        output valid,
        output m0_fwd_compare, output m0_rev_compare,
        output m1_fwd_compare, output m1_rev_compare,
        output m2_fwd_compare, output m2_rev_compare,
        output m3_fwd_compare, output m3_rev_compare,
        output active_motion, output event_code,
        input  ready
    );
    modport sink (
        input  valid,
        input  m0_fwd_compare, input m0_rev_compare,
        input  m1_fwd_compare, input m1_rev_compare,
        input  m2_fwd_compare, input m2_rev_compare,
        input  m3_fwd_compare, input m3_rev_compare,
        input  active_motion, input event_code,
        output ready
    );
endinterface

>>> rtl/core/sthc_front.sv
`timescale 1ns / 1ps

// Parser and watchdog: classifies each input word and updates the motion state.
module sthc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           timeout_ticks,
    sthc_in_if.sink               cmd_in,
    input  logic                  queue_full,
    output logic                  push,
    output sthc_pkg::motion_item_t item
);

    typedef enum logic [2:0] {
        ESC_IDLE        = 3'b001,
        ESC_GOT_ESC     = 3'b010,
        ESC_GOT_BRACKET = 3'b100
    } esc_phase_t;

    esc_phase_t          phase_reg, phase_next;
    sthc_pkg::motion_t   motion_reg, motion_next;
    logic [15:0]         ticks_reg, ticks_next;
    sthc_pkg::motion_t   key_motion;
    logic                key_hit;
    sthc_pkg::event_t    evt;
    logic                accept;

    // A word is taken whenever the queue has room.
    assign cmd_in.ready = !queue_full;
    assign accept       = cmd_in.valid && !queue_full;

    // Byte decoding for the escape sequence and the stop keys.
    always_comb
    begin
        phase_next = phase_reg;
        key_hit    = 1'b0;
        key_motion = motion_reg;
        case (phase_reg)
            ESC_IDLE:
            begin
                if (cmd_in.rx_byte == sthc_pkg::BYTE_ESC)
                begin
                    phase_next = ESC_GOT_ESC;
                end
                else if (cmd_in.rx_byte == sthc_pkg::BYTE_SPACE ||
                         cmd_in.rx_byte == sthc_pkg::BYTE_LOWER_S ||
                         cmd_in.rx_byte == sthc_pkg::BYTE_UPPER_S)
                begin
                    key_hit    = 1'b1;
                    key_motion = sthc_pkg::MOT_STOP;
                end
            end
            ESC_GOT_ESC:
            begin
                phase_next = (cmd_in.rx_byte == sthc_pkg::BYTE_LBRACKET) ?
                             ESC_GOT_BRACKET : ESC_IDLE;
            end
            ESC_GOT_BRACKET:
            begin
                phase_next = ESC_IDLE;
                case (cmd_in.rx_byte)
                    sthc_pkg::BYTE_KEY_A:
                    begin
                        key_hit    = 1'b1;
                        key_motion = sthc_pkg::MOT_FWD;
                    end
                    sthc_pkg::BYTE_KEY_B:
                    begin
                        key_hit    = 1'b1;
                        key_motion = sthc_pkg::MOT_REV;
                    end
                    sthc_pkg::BYTE_KEY_C:
                    begin
                        key_hit    = 1'b1;
                        key_motion = sthc_pkg::MOT_RIGHT;
                    end
                    sthc_pkg::BYTE_KEY_D:
                    begin
                        key_hit    = 1'b1;
                        key_motion = sthc_pkg::MOT_LEFT;
                    end
                    default:
                    begin
                        key_hit = 1'b0;
                    end
                endcase
            end
            default:
            begin
                phase_next = ESC_IDLE;
            end
        endcase
    end

    // Motion, tick count and event for the word, with the timeout checked last.
    always_comb
    begin
        motion_next = motion_reg;
        ticks_next  = ticks_reg;
        evt         = sthc_pkg::EVT_NONE;
        if (cmd_in.command == sthc_pkg::CMD_BYTE)
        begin
            if (key_hit)
            begin
                motion_next = key_motion;
                ticks_next  = '0;
                evt         = sthc_pkg::EVT_COMMAND;
            end
        end
        else if (ticks_reg != sthc_pkg::TICKS_MAX)
        begin
            ticks_next = ticks_reg + 16'd1;
        end
        if (motion_next != sthc_pkg::MOT_STOP && ticks_next > timeout_ticks)
        begin
            motion_next = sthc_pkg::MOT_STOP;
            evt         = sthc_pkg::EVT_TIMEOUT;
        end
    end

    // State updates only on accepted words; ticks leave the parser alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ESC_IDLE;
            motion_reg <= sthc_pkg::MOT_STOP;
            ticks_reg  <= '0;
        end
        else if (accept)
        begin
            if (cmd_in.command == sthc_pkg::CMD_BYTE)
            begin
                phase_reg <= phase_next;
            end
            motion_reg <= motion_next;
            ticks_reg  <= ticks_next;
        end
    end

    assign push        = accept;
    assign item.motion = motion_next;
    assign item.evt    = evt;

endmodule

>>> rtl/core/sthc_queue.sv
`timescale 1ns / 1ps

// Short FIFO between the parser and the drive stage.
module sthc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sthc_pkg::motion_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output sthc_pkg::motion_item_t pop_item,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sthc_pkg::motion_item_t entries_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entries_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; only entries counted as full are read.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/sthc_back.sv
`timescale 1ns / 1ps

// Drive stage: turns a motion into compare values and holds the output word.
module sthc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [6:0]             drive_duty,
    input  logic [15:0]            pwm_period,
    input  sthc_pkg::motion_item_t item,
    input  logic                   item_valid,
    output logic                   item_pop,
    sthc_out_if.source             drive_out
);

    localparam int SHIFT = sthc_pkg::RECIP_SHIFT;

    logic [16:0]           period_plus;
    logic [47:0]           product;
    logic [16:0]           quotient;
    logic [15:0]           pulse_next;
    logic [15:0]           pulse_reg;
    logic                  out_valid_reg;
    logic                  load;
    logic [15:0]           side0_fwd, side0_rev, side1_fwd, side1_rev;
    logic [15:0]           m0_fwd_reg, m0_rev_reg, m1_fwd_reg, m1_rev_reg;
    logic [15:0]           m2_fwd_reg, m2_rev_reg, m3_fwd_reg, m3_rev_reg;
    logic [2:0]            motion_out_reg;
    logic [1:0]            event_out_reg;

    // Pulse width from the configuration, recomputed every cycle.
    assign period_plus = {1'b0, pwm_period} + 17'd1;
    assign product     = 48'(period_plus) * 48'(sthc_pkg::DUTY_FACTOR[drive_duty]);
    assign quotient    = product[SHIFT+16:SHIFT];
    assign pulse_next  = (quotient > {1'b0, pwm_period}) ? pwm_period : quotient[15:0];

    always_ff @(posedge clk)
    begin
        pulse_reg <= pulse_next;
    end

    // Per-side direction: motors 0 and 2 form side 0, motors 1 and 3 side 1.
    always_comb
    begin
        side0_fwd = '0;
        side0_rev = '0;
        side1_fwd = '0;
        side1_rev = '0;
        case (item.motion)
            sthc_pkg::MOT_FWD:
            begin
                side0_fwd = pulse_reg;
                side1_fwd = pulse_reg;
            end
            sthc_pkg::MOT_REV:
            begin
                side0_rev = pulse_reg;
                side1_rev = pulse_reg;
            end
            sthc_pkg::MOT_LEFT:
            begin
                side0_rev = pulse_reg;
                side1_fwd = pulse_reg;
            end
            sthc_pkg::MOT_RIGHT:
            begin
                side0_fwd = pulse_reg;
                side1_rev = pulse_reg;
            end
            default:
            begin
                side0_fwd = '0;
            end
        endcase
    end

    // The output register refills whenever an item is waiting and the register is empty or being drained.
    assign load     = item_valid && (!out_valid_reg || drive_out.ready);
    assign item_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m0_fwd_reg     <= side0_fwd;
            m0_rev_reg     <= side0_rev;
            m1_fwd_reg     <= side1_fwd;
            m1_rev_reg     <= side1_rev;
            m2_fwd_reg     <= side0_fwd;
            m2_rev_reg     <= side0_rev;
            m3_fwd_reg     <= side1_fwd;
            m3_rev_reg     <= side1_rev;
            motion_out_reg <= item.motion;
            event_out_reg  <= item.evt;
        end
    end

    assign drive_out.valid          = out_valid_reg;
    assign drive_out.m0_fwd_compare = m0_fwd_reg;
    assign drive_out.m0_rev_compare = m0_rev_reg;
    assign drive_out.m1_fwd_compare = m1_fwd_reg;
    assign drive_out.m1_rev_compare = m1_rev_reg;
    assign drive_out.m2_fwd_compare = m2_fwd_reg;
    assign drive_out.m2_rev_compare = m2_rev_reg;
    assign drive_out.m3_fwd_compare = m3_fwd_reg;
    assign drive_out.m3_rev_compare = m3_rev_reg;
    assign drive_out.active_motion  = motion_out_reg;
    assign drive_out.event_code     = event_out_reg;

endmodule

>>> rtl/core/serial_teleop_hbridge_controller_core.sv
// An accepted word is written into the FIFO and then loaded into the output register that drives drive_out.
// Throughput: one word per cycle while the FIFO has room; the parser state and the FIFO advance only when words move.
// A configuration write applies to words accepted from the following cycle on.
// Reset (rst_n low, asynchronous): parser idle, motion stop, tick count zero,
// FIFO and output empty, duty 22, period 3199, timeout 400.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_teleop_hbridge_controller_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    sthc_in_if.sink     cmd_in,
    sthc_out_if.source  drive_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [6:0]             drive_duty_reg;
    logic [15:0]            pwm_period_reg;
    logic [15:0]            timeout_ticks_reg;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;
    sthc_pkg::motion_item_t push_item;
    sthc_pkg::motion_item_t pop_item;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_duty_reg    <= sthc_pkg::DUTY_RESET;
            pwm_period_reg    <= sthc_pkg::PERIOD_RESET;
            timeout_ticks_reg <= sthc_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sthc_pkg::CFG_DRIVE_DUTY:    drive_duty_reg    <= cfg_wdata[6:0];
                sthc_pkg::CFG_PWM_PERIOD:    pwm_period_reg    <= cfg_wdata;
                sthc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default:                     drive_duty_reg    <= drive_duty_reg;
            endcase
        end
    end

    sthc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_ticks_reg),
        .cmd_in        (cmd_in),
        .queue_full    (queue_full),
        .push          (push),
        .item          (push_item)
    );

    sthc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    sthc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .drive_duty   (drive_duty_reg),
        .pwm_period   (pwm_period_reg),
        .item         (pop_item),
        .item_valid   (!queue_empty),
        .item_pop     (pop),
        .drive_out    (drive_out)
    );

    // The parser never pushes into a full FIFO.
    `STHC_ASSERT_NOW(a_no_overflow, push, !queue_full, "push into full queue")
    // An accepted word is queued by the next cycle.
    `STHC_ASSERT_NEXT(a_accept_queued, cmd_in.valid && cmd_in.ready, !queue_empty, "accepted word lost")
    // A timeout word always shows the brake state.
    `STHC_ASSERT_NOW(a_timeout_stop, drive_out.valid && drive_out.event_code == sthc_pkg::EVT_TIMEOUT, drive_out.active_motion == sthc_pkg::MOT_STOP, "timeout without stop")
    // Braking drives both sides of every motor low; this checks m0 forward, m1 reverse and m3 forward.
    `STHC_ASSERT_NOW(a_stop_brakes, drive_out.valid && drive_out.active_motion == sthc_pkg::MOT_STOP, drive_out.m0_fwd_compare == 16'd0 && drive_out.m1_rev_compare == 16'd0 && drive_out.m3_fwd_compare == 16'd0, "stop with nonzero compare")

endmodule
